// ----- sv/ctfm_pkg.sv -----
// Package for the color tolerance first-match block.
// Holds register indexes, mode codes and fixed-point constants; no dependencies.
package ctfm_pkg;

  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 24;

  localparam logic [CfgIdxBits-1:0] RegTarget    = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegTolerance = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegMode      = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegHueScale  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegSatScale  = 3'd4;

  localparam logic [1:0] ModeMax    = 2'd0;
  localparam logic [1:0] ModeEucl   = 2'd1;
  localparam logic [1:0] ModeHsl    = 2'd2;
  // no pixel ever matches in this mode
  localparam logic [1:0] ModeUnused = 2'd3;

  // hue: 60 degrees with 8 fraction bits
  localparam logic [13:0] HueUnit = 14'd15360;
  localparam logic [16:0] Hue120  = 17'd30720;
  localparam logic [16:0] Hue240  = 17'd61440;
  localparam logic [16:0] Hue360  = 17'd92160;

  // work handed to the shared divider
  typedef struct packed {
    logic [21:0] num;
    logic [8:0]  den;
  } div_req_t;

endpackage

// ----- sv/ctfm_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ctfm_pkg for the request struct.
module ctfm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ctfm_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [21:0]       quot_o
);
  import ctfm_pkg::*;

  logic [21:0] q_q, q_d;
  logic [9:0]  rem_q, rem_d;
  logic [8:0]  den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [9:0]  trial;
  logic [10:0] sub;

  assign trial = {rem_q[8:0], q_q[21]};
  assign sub   = {1'b0, trial} - {2'b0, den_q};
  assign quot_o = q_q;
  assign done_o = busy_q && (cnt_q == 5'd0);

  always_comb begin
    q_d = q_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      q_d = req_i.num; rem_d = '0; den_d = req_i.den; cnt_d = 5'd22; busy_d = 1'b0;
    end else if (cnt_q != 5'd0) begin
      if (!sub[10]) begin
        rem_d = sub[9:0];
        q_d = {q_q[20:0], 1'b1};
      end else begin
        rem_d = trial;
        q_d = {q_q[20:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      busy_d = 1'b1;
    end else begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule

// ----- sv/color_tolerance_first_match.sv -----
// Color tolerance first-match: max, Euclidean and HSL compare against a target.
// Modes max and Euclidean compare a pixel directly; HSL takes four passes per pixel through the
// one shared 22-bit serial divider, hue and saturation for the pixel and for the target;
// a grey pixel or target skips its two passes.
// The result beat is formed in the output state after the last pixel and waits in an output
// register; a new last pixel holds in its output state until that beat is taken.
// Reset clears the registers to their defaults and the match state.
module color_tolerance_first_match #(
  parameter int unsigned COORD_BITS = ctfm_pkg::CoordBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [ctfm_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [ctfm_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // red, green, blue, pos_x, pos_y, zero fill to bytes
  input  logic [((24+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // found, match_x, match_y, zero fill to bytes
  output logic [((2*COORD_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
  import ctfm_pkg::*;

  localparam int unsigned OW = 2*COORD_BITS + 3;
  localparam int unsigned OB = ((OW+7)/8)*8;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StCmp  = 3'd1;
  localparam logic [2:0] StHue  = 3'd2;
  localparam logic [2:0] StSat  = 3'd3;
  localparam logic [2:0] StEval = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [23:0] tgt_q;
  logic [8:0]  tol_q;
  logic [1:0]  mode_q;
  logic [7:0]  hsc_q, ssc_q;
  logic [2:0]  st_q, st_d;
  logic [7:0]  r_q, g_q, b_q;
  logic [COORD_BITS-1:0] x_q, y_q, fx_q, fy_q;
  logic        last_q, have_q;
  logic        side_q; // 0 pixel, 1 target
  logic [16:0] hp_q, ht_q;
  logic [8:0]  sp_q, st2_q;
  logic        dsent_q;
  logic        mv_q;
  logic [OW-1:0] mdata_q;
  logic        hit;

  // operands of the side under work
  logic [7:0] cr, cg, cb, mx, mn, d8, n8;
  logic [8:0] sum, sden;
  logic [1:0] sect;
  logic       neg;
  div_req_t   req;
  logic       dstart, ddone;
  logic [21:0] dq;

  always_comb begin
    cr = side_q ? tgt_q[7:0] : r_q;
    cg = side_q ? tgt_q[15:8] : g_q;
    cb = side_q ? tgt_q[23:16] : b_q;
    mx = cr; mn = cr;
    if (cg > mx) mx = cg;
    if (cb > mx) mx = cb;
    if (cg < mn) mn = cg;
    if (cb < mn) mn = cb;
    d8 = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    sden = (sum <= 9'd255) ? sum : 9'd510 - sum;
    if (mx == cr) begin
      sect = 2'd0; neg = cg < cb; n8 = neg ? cb - cg : cg - cb;
    end else if (mx == cg) begin
      sect = 2'd1; neg = cb < cr; n8 = neg ? cr - cb : cb - cr;
    end else begin
      sect = 2'd2; neg = cr < cg; n8 = neg ? cg - cr : cr - cg;
    end
    req.den = {1'b0, d8};
    req.num = {n8, 14'd0} - {4'd0, n8, 10'd0}; // n*15360 = n*16384 - n*1024
    if (st_q == StSat) begin
      req.den = sden;
      req.num = {6'd0, d8, 8'd0};
    end
  end

  assign dstart = (st_q == StHue || st_q == StSat) && !dsent_q && d8 != 8'd0;

  ctfm_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .req_i(req), .done_o(ddone), .quot_o(dq)
  );

  logic [16:0] hue_v, base;
  always_comb begin
    unique case (sect)
      2'd0:    base = neg ? Hue360 : 17'd0;
      2'd1:    base = Hue120;
      default: base = Hue240;
    endcase
    hue_v = neg ? base - dq[16:0] : base + dq[16:0];
  end

  // max, Euclidean and HSL compare
  logic [7:0]  dr, dg, db;
  logic [17:0] dsq;
  logic [16:0] hdf, hth;
  logic [8:0]  sdf;
  logic [16:0] sth;
  always_comb begin
    dr = (r_q > tgt_q[7:0]) ? r_q - tgt_q[7:0] : tgt_q[7:0] - r_q;
    dg = (g_q > tgt_q[15:8]) ? g_q - tgt_q[15:8] : tgt_q[15:8] - g_q;
    db = (b_q > tgt_q[23:16]) ? b_q - tgt_q[23:16] : tgt_q[23:16] - b_q;
    dsq = {2'd0, {8'd0, dr} * {8'd0, dr}} + {2'd0, {8'd0, dg} * {8'd0, dg}}
        + {2'd0, {8'd0, db} * {8'd0, db}};
    hdf = (hp_q > ht_q) ? hp_q - ht_q : ht_q - hp_q;
    sdf = (sp_q > st2_q) ? sp_q - st2_q : st2_q - sp_q;
    hth = tol_q * hsc_q;
    sth = tol_q * ssc_q;
    hit = 1'b0;
    unique case (mode_q)
      ModeMax:  hit = dr <= tol_q && dg <= tol_q && db <= tol_q;
      ModeEucl: hit = dsq <= tol_q * tol_q;
      ModeHsl:  hit = hdf <= hth && {8'd0, sdf} <= sth;
      default:  hit = 1'b0;
    endcase
  end

  assign s_axis_tready = (st_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata = {{(OB-OW){1'b0}}, mdata_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (s_axis_tvalid) st_d = (mode_q == ModeHsl) ? StHue : StCmp;
      StHue:  if (d8 == 8'd0 || ddone) st_d = StSat;
      StSat:  if (d8 == 8'd0 || ddone) st_d = side_q ? StEval : StHue;
      StCmp, StEval: st_d = last_q ? StOut : StIdle;
      StOut:  if (!mv_q || m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; tgt_q <= '0; tol_q <= '0; mode_q <= ModeEucl;
      hsc_q <= 8'd51; ssc_q <= 8'd51; have_q <= 1'b0; fx_q <= '0; fy_q <= '0;
      side_q <= 1'b0; dsent_q <= 1'b0; mv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegTarget:    tgt_q <= cfg_data_i;
          RegTolerance: tol_q <= cfg_data_i[8:0];
          RegMode:      mode_q <= cfg_data_i[1:0];
          RegHueScale:  hsc_q <= cfg_data_i[7:0];
          RegSatScale:  ssc_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      // a new beat replaces the one taken at this edge
      if (st_q == StOut && st_d == StIdle) mv_q <= 1'b1;
      else if (mv_q && m_axis_tready) mv_q <= 1'b0;
      if (st_q == StIdle) begin
        side_q <= 1'b0; dsent_q <= 1'b0;
      end
      if (st_q == StHue || st_q == StSat) begin
        if (dstart) dsent_q <= 1'b1;
        if (d8 == 8'd0 || ddone) begin
          dsent_q <= 1'b0;
          if (st_q == StSat) side_q <= 1'b1;
        end
      end
      if ((st_q == StCmp || st_q == StEval) && !have_q && hit) begin
        have_q <= 1'b1; fx_q <= x_q; fy_q <= y_q;
      end
      if (st_q == StOut && st_d == StIdle) begin
        have_q <= 1'b0; fx_q <= '0; fy_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && s_axis_tvalid) begin
      r_q <= s_axis_tdata[7:0];
      g_q <= s_axis_tdata[15:8];
      b_q <= s_axis_tdata[23:16];
      x_q <= s_axis_tdata[24 +: COORD_BITS];
      y_q <= s_axis_tdata[24+COORD_BITS +: COORD_BITS];
      last_q <= s_axis_tlast;
    end
    if (st_q == StHue && (d8 == 8'd0 || ddone)) begin
      if (side_q) ht_q <= (d8 == 8'd0) ? 17'd0 : hue_v;
      else        hp_q <= (d8 == 8'd0) ? 17'd0 : hue_v;
    end
    if (st_q == StSat && (d8 == 8'd0 || ddone)) begin
      if (side_q) st2_q <= (d8 == 8'd0) ? 9'd0 : dq[8:0];
      else        sp_q  <= (d8 == 8'd0) ? 9'd0 : dq[8:0];
    end
    if (st_q == StOut && st_d == StIdle) begin
      mdata_q <= have_q ? {1'b0, fy_q, 1'b0, fx_q, 1'b1}
                        : {{(2*COORD_BITS+2){1'b1}}, 1'b0};
    end
  end
endmodule
